// ----- src/sd_four_line_crc16_assert.svh -----
// assertion macros shared by the sd four line crc16 block
`ifndef SD_FOUR_LINE_CRC16_ASSERT_SVH
`define SD_FOUR_LINE_CRC16_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SDC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sdc assertion failed");

// next-cycle implication, checked out of reset
`define SDC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sdc assertion failed");

`endif

// ----- src/sdc_pkg.sv -----
// types, constants and the crc bit step for the sd four line crc16 block
package sdc_pkg;

   localparam int DATA_LINES = 4;
   localparam int CRC_W      = 16;
   localparam int CRC_BYTES  = 8;
   localparam int CNT_W      = $clog2(CRC_BYTES + 1);

   localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

   typedef logic [CRC_W-1:0] crc_line_type;
   typedef logic [DATA_LINES-1:0][CRC_W-1:0] crc_set_type;

   // finished crcs handed from the lanes to the emitter
   typedef struct packed {
      logic        load;
      crc_set_type lines;
   } snap_type;

   // one msb-first crc16 step
   function automatic crc_line_type crc_bit(input crc_line_type r, input logic b);
      logic         fb;
      crc_line_type n;
      fb = r[CRC_W-1] ^ b;
      n  = {r[CRC_W-2:0], 1'b0};
      if (fb) begin
         n = n ^ CRC_POLY;
      end
      return n;
   endfunction

endpackage

// ----- src/sdc_req_if.sv -----
// data byte channel of the sd four line crc16 block
interface sdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/sdc_rsp_if.sv -----
// crc byte channel of the sd four line crc16 block
interface sdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] crc_byte;
   logic       crc_last;

   modport source (output valid, output crc_byte, output crc_last, input ready);
   modport sink (input valid, input crc_byte, input crc_last, output ready);
endinterface

// ----- src/sdc_crc_lanes.sv -----
// input register and the four per-line crc16 registers
module sdc_crc_lanes
   import sdc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sdc_req_if.sink   req,
   input  logic      emit_free,
   output snap_type  snap
);

   logic                    in_valid_ff;
   logic [2*DATA_LINES-1:0] in_data_ff;
   logic                    in_last_ff;
   crc_set_type             crc_ff;
   crc_set_type             crc_in;
   logic                    advance;

   // a last item waits until the emitter can take its crcs
   assign advance   = in_valid_ff && (!in_last_ff || emit_free);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      crc_line_type c1;
      for (int ln = 0; ln < DATA_LINES; ln++) begin
         // high nibble first, then low nibble
         c1         = crc_bit(crc_ff[ln], in_data_ff[DATA_LINES + ln]);
         crc_in[ln] = crc_bit(c1, in_data_ff[ln]);
      end
   end

   assign snap.load  = advance && in_last_ff;
   assign snap.lines = crc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         crc_ff      <= '0;
      end else begin
         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            crc_ff <= in_last_ff ? '0 : crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_data_ff <= req.data_byte;
         in_last_ff <= req.last_byte;
      end
   end

endmodule

// ----- src/sdc_emit.sv -----
// holds a finished crc set and sends it out two bits per line per byte
module sdc_emit
   import sdc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  snap_type  snap,
   sdc_rsp_if.source rsp,
   output logic      emit_free
);

   crc_set_type      lines_ff;
   logic [CNT_W-1:0] count_ff;
   logic             done;

   assign done      = count_ff == CNT_W'(1);
   assign rsp.valid = count_ff != '0;
   assign rsp.crc_last = done;
   assign emit_free = (count_ff == '0) || (done && rsp.ready);

   always_comb begin
      logic [DATA_LINES-1:0] hi;
      logic [DATA_LINES-1:0] lo;
      for (int ln = 0; ln < DATA_LINES; ln++) begin
         hi[ln] = lines_ff[ln][CRC_W-1];
         lo[ln] = lines_ff[ln][CRC_W-2];
      end
      rsp.crc_byte = {hi, lo};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (snap.load) begin
         count_ff <= CNT_W'(CRC_BYTES);
      end else if (rsp.valid && rsp.ready) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (snap.load) begin
         lines_ff <= snap.lines;
      end else if (rsp.valid && rsp.ready) begin
         for (int ln = 0; ln < DATA_LINES; ln++) begin
            lines_ff[ln] <= {lines_ff[ln][CRC_W-3:0], 2'b00};
         end
      end
   end

endmodule

// ----- src/sd_four_line_crc16.sv -----
// sd card 4-bit data bus crc16 generator, four lines
//
// req carries data bytes of a block (data_byte, high nibble first) and
// last_byte on the final one. each nibble bit feeds its own line's crc16
// (poly 0x1021, zero start, msb first). rsp carries eight crc bytes per
// block in transmit order, crc_last on the eighth.
// a data item is registered on accept and absorbed at the next edge, so one
// item per cycle is taken while no block end is pending. the edge that absorbs
// a last item also loads the emitter, so the first crc byte is valid right
// after it and stays on rsp until it is taken with rsp.ready; then one
// byte per cycle while rsp.ready is high; the emit shift register sets that rate.
// the next block's data streams in while crc bytes still go out; a second
// last item waits in the input register until the eighth byte is taken.
// a stall on rsp holds the current crc byte. synchronous reset clears the
// crcs, the input register and the emit count; nothing is sent after reset.
module sd_four_line_crc16
   import sdc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   sdc_req_if.sink   req,
   sdc_rsp_if.source rsp
);

   snap_type snap;
   logic     emit_free;

   sdc_crc_lanes u_lanes (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .emit_free (emit_free),
      .snap      (snap)
   );

   sdc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .snap      (snap),
      .rsp       (rsp),
      .emit_free (emit_free)
   );

`include "sd_four_line_crc16_assert.svh"

   `SDC_ASSERT_NOW(a_load_when_free, snap.load, emit_free)
   `SDC_ASSERT_NEXT(a_load_shows, snap.load, rsp.valid && !rsp.crc_last)
   `SDC_ASSERT_NEXT(a_idle_after_last, rsp.valid && rsp.ready && rsp.crc_last && !snap.load,
                    !rsp.valid)

endmodule

// ----- sim/sdc_crc_checker.sv -----
// watches both channels of the crc block, predicts the line crc bytes and compares them
`timescale 1ns / 1ps

module sdc_crc_checker
   import sdc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sdc_req_if   req,
   sdc_rsp_if   rsp,
   output int   mismatch_count,
   output int   crc_pending,
   output int   blocks_closed
);

   typedef struct packed {
      logic [7:0] crc_byte;
      logic       crc_last;
   } crc_item_type;

   crc_set_type  lane_crc;
   crc_item_type crc_byte_queue[$];

   // one msb-first step of a line crc16
   function automatic crc_line_type shift_in_bit(input crc_line_type r, input logic b);
      crc_line_type n;
      n = {r[CRC_W-2:0], 1'b0};
      if (r[CRC_W-1] ^ b) begin
         n = n ^ CRC_POLY;
      end
      return n;
   endfunction

   // absorb one data byte into the four line crcs; a last byte queues the crc bytes
   task automatic absorb_data_byte(input logic [7:0] data, input logic last);
      logic [3:0]   nib;
      int           pos;
      crc_item_type item;
      for (int h = 1; h >= 0; h--) begin
         nib = data[h*4 +: 4];
         for (int ln = 0; ln < DATA_LINES; ln++) begin
            lane_crc[ln] = shift_in_bit(lane_crc[ln], nib[ln]);
         end
      end
      if (last) begin
         for (int k = 0; k < CRC_BYTES; k++) begin
            pos = CRC_W - 1 - 2 * k;
            for (int ln = 0; ln < DATA_LINES; ln++) begin
               item.crc_byte[4 + ln] = lane_crc[ln][pos];
               item.crc_byte[ln]     = lane_crc[ln][pos - 1];
            end
            item.crc_last = (k == CRC_BYTES - 1);
            crc_byte_queue.push_back(item);
         end
         lane_crc = '0;
         blocks_closed++;
      end
   endtask

   always @(posedge clock) begin : watch
      crc_item_type got;
      crc_item_type want;
      if (reset) begin
         lane_crc = '0;
         crc_byte_queue.delete();
         mismatch_count = 0;
         blocks_closed = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.crc_byte = rsp.crc_byte;
            got.crc_last = rsp.crc_last;
            if (crc_byte_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: crc byte %02h last %0b arrived with none expected",
                           $realtime, got.crc_byte, got.crc_last);
               end
            end else begin
               want = crc_byte_queue.pop_front();
               if (got.crc_byte !== want.crc_byte || got.crc_last !== want.crc_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: crc byte mismatch, expected %02h last %0b, got %02h last %0b",
                              $realtime, want.crc_byte, want.crc_last,
                              got.crc_byte, got.crc_last);
                  end
               end
            end
         end
         if (req.valid && req.ready) begin
            absorb_data_byte(req.data_byte, req.last_byte);
         end
      end
      crc_pending = crc_byte_queue.size();
   end

endmodule

// ----- sim/sd_four_line_crc16_test.sv -----
// stimulus and verdict for the sd four line crc16 block
`timescale 1ns / 1ps

module sd_four_line_crc16_test;

   localparam int STALL_LIMIT  = 4000;
   localparam int TARGET_BYTES = 300;

   logic clock;
   logic reset;
   bit   quiet_run;
   int   bytes_sent;
   int   mismatch_count;
   int   crc_pending;
   int   blocks_closed;
   int   stall_cycles;

   sdc_req_if req ();
   sdc_rsp_if rsp ();

   sd_four_line_crc16 DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   sdc_crc_checker crc_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .mismatch_count (mismatch_count),
      .crc_pending    (crc_pending),
      .blocks_closed  (blocks_closed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // crc byte sink, with occasional back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= quiet_run || ($urandom_range(99) >= 6);
      end
   end

   // ends the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("no item moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the item is taken
   task automatic send_data_byte(input logic [7:0] data, input logic last);
      while (!quiet_run && $urandom_range(99) < 6) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid     <= 1'b1;
      req.data_byte <= data;
      req.last_byte <= last;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_block(input int length);
      for (int i = 0; i < length; i++) begin
         send_data_byte(8'($urandom), i == length - 1);
      end
   endtask

   task automatic drain_crc_bytes();
      req.valid <= 1'b0;
      @(negedge clock);
      while (crc_pending != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int block_count;
      int length;
      req.valid     = 1'b0;
      req.data_byte = 8'h00;
      req.last_byte = 1'b0;
      reset         = 1'b1;
      quiet_run     = 1'b0;
      bytes_sent    = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single-byte blocks at the extremes, then two-, four- and eight-byte blocks, with no drain between them
      send_data_byte(8'h00, 1'b1);
      send_data_byte(8'hff, 1'b1);
      send_data_byte(8'h80, 1'b1);
      send_data_byte(8'h01, 1'b1);
      send_data_byte(8'h01, 1'b0);
      send_data_byte(8'h10, 1'b1);
      send_data_byte(8'ha5, 1'b0);
      send_data_byte(8'h5a, 1'b0);
      send_data_byte(8'hff, 1'b0);
      send_data_byte(8'h00, 1'b1);
      for (int i = 0; i < 8; i++) begin
         send_data_byte(8'(8'h12 + 8'h22 * i), i == 7);
      end
      drain_crc_bytes();

      block_count = 0;
      while (bytes_sent < TARGET_BYTES) begin
         // mostly short blocks, now and then a long one
         if ($urandom_range(9) == 0) begin
            length = $urandom_range(40, 9);
         end else begin
            length = $urandom_range(8, 1);
         end
         quiet_run = (block_count >= 12 && block_count < 20);
         send_random_block(length);
         block_count++;
         if (block_count == 6 || $urandom_range(15) == 0) begin
            drain_crc_bytes();
         end
      end
      quiet_run = 1'b0;
      req.valid <= 1'b0;
      @(negedge clock);

      while (crc_pending != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);

      $display("sent %0d data bytes in %0d blocks of 1 to 40 bytes,", bytes_sent, blocks_closed);
      $display("with random gaps, crc back-pressure, a gap-free stretch and drained pauses");
      if (mismatch_count == 0 && crc_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
